>>> design/fsba_pkg.sv
// Package for the fixed-size block allocator: request/response payload types,
// operation, status and register codes, and default sizes.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package fsba_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_BLOCKS_DEFAULT = 256;
   localparam int WORD_BYTES_DEFAULT = 8;

   // Field widths fixed by the interface
   localparam int OPERATION_WIDTH   = 2;
   localparam int FREE_INDEX_WIDTH  = 8;
   localparam int STATUS_WIDTH      = 2;
   localparam int BLOCK_INDEX_WIDTH = 8;
   localparam int OFFSET_WIDTH      = 24;
   localparam int COUNT_WIDTH       = 9;
   localparam int BLOCK_BYTES_WIDTH = 16;

   // Register file
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   // Saturation limit of the free counter
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   typedef enum logic [OPERATION_WIDTH-1:0] {
      OP_ALLOC   = 2'd0,
      OP_FREE    = 2'd1,
      OP_REBUILD = 2'd2
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   // Register index taken from paddr[2]
   typedef enum logic [0:0] {
      REG_BLOCK_COUNT = 1'b0,
      REG_BLOCK_BYTES = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [OPERATION_WIDTH-1:0]  operation;
      logic [FREE_INDEX_WIDTH-1:0] free_index;
   } req_type;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0]      status;
      logic [BLOCK_INDEX_WIDTH-1:0] block_index;
      logic [OFFSET_WIDTH-1:0]      block_offset;
      logic [COUNT_WIDTH-1:0]       free_count;
   } rsp_type;

endpackage

`default_nettype wire

>>> design/fsba_if.sv
// Valid/ready channel interfaces for the block allocator's request and
// response transactions. Depends on fsba_pkg for the payload types.
`default_nettype none

interface fsba_req_if;
   logic             valid;
   logic             ready;
   fsba_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface fsba_rsp_if;
   logic             valid;
   logic             ready;
   fsba_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> design/fixed_size_block_allocator.sv
// Fixed-size block allocator over a LIFO free list of block indices.
// Depends on fsba_pkg and the channel interfaces in fsba_if.sv.
//
// Usage:
//  - req_chan carries one request per transaction: allocate, free or rebuild.
//    rsp_chan returns exactly one response per request, in order: status,
//    granted index and byte offset, and the free count after the request.
//  - csr_* is an APB-style register port: block_count at 0x0, block_bytes at
//    0x4. Writes are expected only while the allocator is idle. block_count
//    takes effect at the next rebuild and bounds free indices at once.
//  - The response is registered: it goes to the output register, or to the
//    skid register while the receiver stalls. One request per cycle while
//    req_chan.ready is high; the list head and its successor are held in
//    registers and the successor's link is prefetched from the link RAM each
//    cycle, so back-to-back allocates and frees do not wait on the RAM read.
//  - Rebuild is lazy: a background pointer writes the ascending links into
//    the link RAM in every cycle the write port is free and no rebuild is
//    taken. A free of a block that pointer has not reached yet (possible
//    only for a block that was never handed out since the rebuild) waits
//    until it has.
//  - Reset: the list holds blocks 0..min(256, MAX_BLOCKS)-1 in ascending
//    order, block_count is 256 and block_bytes is 8.
//  - Receiver stall: a response waits in the output register; one more
//    request is taken into a skid register, then req_chan.ready drops.
`default_nettype none

module fixed_size_block_allocator #(
   parameter int MAX_BLOCKS = fsba_pkg::MAX_BLOCKS_DEFAULT,
   parameter int WORD_BYTES = fsba_pkg::WORD_BYTES_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   fsba_req_if.sink                                 req_chan,
   fsba_rsp_if.source                               rsp_chan,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [fsba_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [fsba_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [fsba_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                     csr_pready
);

   // Index widths: AW addresses the link RAM, CW also holds the end marker
   localparam int AW   = $clog2(MAX_BLOCKS);
   localparam int CW   = AW + 1;
   localparam int CMPW = (CW > fsba_pkg::COUNT_WIDTH) ? CW : fsba_pkg::COUNT_WIDTH;
   localparam int MULW = (CW > fsba_pkg::OFFSET_WIDTH) ? CW : fsba_pkg::OFFSET_WIDTH;
   localparam logic [CW-1:0] LIST_END = CW'(MAX_BLOCKS);

   // Block size rounding: q = floor(num / WORD_BYTES) by reciprocal multiply
   localparam int NUMW   = fsba_pkg::BLOCK_BYTES_WIDTH + 1;
   localparam int ALW    = fsba_pkg::BLOCK_BYTES_WIDTH + 1;
   localparam int SHIFT  = NUMW + $clog2(WORD_BYTES);
   localparam int RECIPW = SHIFT + 1;
   localparam logic [RECIPW-1:0] RECIP = RECIPW'(((64'd1 << SHIFT) + WORD_BYTES - 1) / WORD_BYTES);
   localparam logic [ALW-1:0] WORD_ALW      = ALW'(WORD_BYTES);
   localparam logic [ALW-1:0] RESET_ALIGNED = ALW'(((8 + WORD_BYTES - 1) / WORD_BYTES) * WORD_BYTES);

   // Reset state equals a rebuild with block_count = 256
   localparam int RESET_COUNT = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;
   localparam logic [CW-1:0] RESET_N = CW'(RESET_COUNT);
   localparam logic [fsba_pkg::COUNT_WIDTH-1:0] RESET_FREE =
      fsba_pkg::COUNT_WIDTH'(RESET_COUNT);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [fsba_pkg::COUNT_WIDTH-1:0]       block_count_ff;
   logic [fsba_pkg::BLOCK_BYTES_WIDTH-1:0] block_bytes_ff;
   logic [ALW-1:0]                         aligned_ff;
   logic [ALW-1:0]                         aligned_in;
   logic                                   csr_write;
   fsba_pkg::reg_index_type                csr_index;
   logic [NUMW-1:0]                        round_num;
   logic [NUMW+RECIPW-1:0]                 round_prod;
   logic [NUMW-1:0]                        round_q;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = fsba_pkg::reg_index_type'(csr_paddr[2]);

   // Round the written size up to a whole number of words; a size of zero gives one word
   always_comb begin
      round_num  = NUMW'(csr_pwdata[fsba_pkg::BLOCK_BYTES_WIDTH-1:0]) + NUMW'(WORD_BYTES - 1);
      round_prod = (NUMW+RECIPW)'(round_num) * (NUMW+RECIPW)'(RECIP);
      round_q    = round_prod[SHIFT +: NUMW];
      if (csr_pwdata[fsba_pkg::BLOCK_BYTES_WIDTH-1:0] == '0) begin
         aligned_in = WORD_ALW;
      end else begin
         aligned_in = ALW'(round_q * NUMW'(WORD_BYTES));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= fsba_pkg::COUNT_WIDTH'(256);
         block_bytes_ff <= fsba_pkg::BLOCK_BYTES_WIDTH'(8);
         aligned_ff     <= RESET_ALIGNED;
      end else if (csr_write) begin
         case (csr_index)
            fsba_pkg::REG_BLOCK_COUNT: begin
               block_count_ff <= csr_pwdata[fsba_pkg::COUNT_WIDTH-1:0];
            end
            fsba_pkg::REG_BLOCK_BYTES: begin
               block_bytes_ff <= csr_pwdata[fsba_pkg::BLOCK_BYTES_WIDTH-1:0];
               aligned_ff     <= aligned_in;
            end
            default: ;
         endcase
      end
   end

   // Register read-back
   always_comb begin
      case (csr_index)
         fsba_pkg::REG_BLOCK_COUNT: csr_prdata = fsba_pkg::CSR_DATA_WIDTH'(block_count_ff);
         fsba_pkg::REG_BLOCK_BYTES: csr_prdata = fsba_pkg::CSR_DATA_WIDTH'(block_bytes_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // List state
   // ---------------------------------------------------------------------
   logic [CW-1:0]                    head_ff, head_in;
   logic [CW-1:0]                    second_ff, second_in;   // successor of head
   logic [CW-1:0]                    wm_ff, wm_in;           // lazy link fill pointer
   logic [CW-1:0]                    n_ff, n_in;             // block count of last rebuild
   logic [fsba_pkg::COUNT_WIDTH-1:0] free_blocks_ff, free_blocks_in;
   logic                             expl_ff, expl_in;       // prefetched link is from RAM

   // Link RAM, one read and one write port, registered read
   logic [CW-1:0] link_mem [MAX_BLOCKS];
   logic [CW-1:0] rd_q_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [CW-1:0] mem_wdata;
   logic [AW-1:0] mem_raddr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      // same-cycle write to the read address is forwarded
      if (mem_we && (mem_waddr == mem_raddr)) begin
         rd_q_ff <= mem_wdata;
      end else begin
         rd_q_ff <= link_mem[mem_raddr];
      end
   end

   // ---------------------------------------------------------------------
   // Request decode
   // ---------------------------------------------------------------------
   logic [fsba_pkg::OPERATION_WIDTH-1:0] op;
   logic [CMPW-1:0]                      idx_w;
   logic [CW-1:0]                        idx_c;
   logic                                 idx_ok;
   logic                                 free_wait;
   logic                                 accept;
   logic                                 skid_v_ff, skid_v_in;

   assign op     = req_chan.payload.operation;
   assign idx_w  = CMPW'(req_chan.payload.free_index);
   assign idx_c  = idx_w[CW-1:0];
   assign idx_ok = (idx_w < CMPW'(block_count_ff)) && (idx_w < CMPW'(MAX_BLOCKS));

   // A free must not land at or above the fill pointer
   assign free_wait = (op == fsba_pkg::OP_FREE) && idx_ok && (idx_c >= wm_ff);

   assign req_chan.ready = !skid_v_ff && !free_wait;
   assign accept         = req_chan.valid && req_chan.ready;

   // Effective links: entries at or above the fill pointer are still ascending
   logic [CW-1:0] second_plus, wm_plus;
   logic [CW-1:0] link_second, link_wm;

   assign second_plus = second_ff + CW'(1);
   assign wm_plus     = wm_ff + CW'(1);
   assign link_second = expl_ff ? rd_q_ff : ((second_plus < n_ff) ? second_plus : LIST_END);
   assign link_wm     = (wm_plus < n_ff) ? wm_plus : LIST_END;

   // Rebuild values from the current block_count
   logic [CMPW-1:0]                  bc_w;
   logic [CW-1:0]                    n_rb;
   logic [CMPW-1:0]                  n_rb_w;
   logic [fsba_pkg::COUNT_WIDTH-1:0] free_rb;

   assign bc_w    = CMPW'(block_count_ff);
   assign n_rb    = (bc_w > CMPW'(MAX_BLOCKS)) ? LIST_END : bc_w[CW-1:0];
   assign n_rb_w  = CMPW'(n_rb);
   assign free_rb = (n_rb_w > CMPW'(fsba_pkg::COUNT_MAX)) ? fsba_pkg::COUNT_MAX
                                                          : n_rb_w[fsba_pkg::COUNT_WIDTH-1:0];

   // Byte offset of the head block
   logic [MULW-1:0]                   head_x;
   logic [fsba_pkg::OFFSET_WIDTH-1:0] head_mul;
   logic [fsba_pkg::OFFSET_WIDTH-1:0] offset_mul;

   assign head_x     = MULW'(head_ff);
   assign head_mul   = head_x[fsba_pkg::OFFSET_WIDTH-1:0];
   assign offset_mul = head_mul * fsba_pkg::OFFSET_WIDTH'(aligned_ff);

   // ---------------------------------------------------------------------
   // Next state and response
   // ---------------------------------------------------------------------
   fsba_pkg::rsp_type rsp_new;
   logic              free_wr;
   logic              rebuild;
   logic              fill_en;

   always_comb begin
      head_in        = head_ff;
      second_in      = second_ff;
      wm_in          = wm_ff;
      n_in           = n_ff;
      free_blocks_in = free_blocks_ff;
      free_wr        = 1'b0;
      rebuild        = 1'b0;
      rsp_new        = '0;
      rsp_new.status = fsba_pkg::ST_OK;

      if (accept) begin
         case (op)
            fsba_pkg::OP_ALLOC: begin
               if (head_ff == LIST_END) begin
                  rsp_new.status = fsba_pkg::ST_EMPTY;
               end else begin
                  rsp_new.block_index  = head_x[fsba_pkg::BLOCK_INDEX_WIDTH-1:0];
                  rsp_new.block_offset = offset_mul + fsba_pkg::OFFSET_WIDTH'(WORD_BYTES);
                  head_in   = second_ff;
                  second_in = (second_ff == LIST_END) ? LIST_END : link_second;
                  if (free_blocks_ff != '0) begin
                     free_blocks_in = free_blocks_ff - fsba_pkg::COUNT_WIDTH'(1);
                  end
               end
            end
            fsba_pkg::OP_FREE: begin
               if (!idx_ok) begin
                  rsp_new.status = fsba_pkg::ST_RANGE;
               end else begin
                  free_wr   = 1'b1;
                  head_in   = idx_c;
                  second_in = head_ff;
                  if (free_blocks_ff != fsba_pkg::COUNT_MAX) begin
                     free_blocks_in = free_blocks_ff + fsba_pkg::COUNT_WIDTH'(1);
                  end
               end
            end
            fsba_pkg::OP_REBUILD: begin
               rebuild        = 1'b1;
               n_in           = n_rb;
               head_in        = (n_rb != '0) ? '0 : LIST_END;
               second_in      = (n_rb > CW'(1)) ? CW'(1) : LIST_END;
               wm_in          = '0;
               free_blocks_in = free_rb;
            end
            default: ;
         endcase
      end

      // Background link fill while the write port is free, no rebuild is taken and the fill is not done
      fill_en = !free_wr && !rebuild && (wm_ff < LIST_END);
      if (fill_en) begin
         wm_in = wm_plus;
      end

      rsp_new.free_count = free_blocks_in;
      expl_in            = second_in < wm_in;
   end

   // RAM port control: free or fill write, and prefetch of the link of the next successor
   assign mem_we    = free_wr || fill_en;
   assign mem_waddr = free_wr ? idx_c[AW-1:0] : wm_ff[AW-1:0];
   assign mem_wdata = free_wr ? head_ff : link_wm;
   assign mem_raddr = second_in[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff        <= '0;
         second_ff      <= CW'(1);
         wm_ff          <= '0;
         n_ff           <= RESET_N;
         free_blocks_ff <= RESET_FREE;
         expl_ff        <= 1'b0;
      end else begin
         head_ff        <= head_in;
         second_ff      <= second_in;
         wm_ff          <= wm_in;
         n_ff           <= n_in;
         free_blocks_ff <= free_blocks_in;
         expl_ff        <= expl_in;
      end
   end

   // ---------------------------------------------------------------------
   // Output register with skid stage
   // ---------------------------------------------------------------------
   logic              out_v_ff, out_v_in;
   fsba_pkg::rsp_type out_data_ff, out_data_in;
   fsba_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              rsp_fire;

   assign rsp_fire = out_v_ff && rsp_chan.ready;

   always_comb begin
      out_v_in     = out_v_ff;
      skid_v_in    = skid_v_ff;
      out_data_in  = out_data_ff;
      skid_data_in = skid_data_ff;
      if (skid_v_ff) begin
         if (rsp_fire) begin
            out_data_in = skid_data_ff;
            skid_v_in   = 1'b0;
         end
      end else if (accept) begin
         if (!out_v_ff || rsp_fire) begin
            out_data_in = rsp_new;
            out_v_in    = 1'b1;
         end else begin
            skid_data_in = rsp_new;
            skid_v_in    = 1'b1;
         end
      end else if (rsp_fire) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_chan.valid   = out_v_ff;
   assign rsp_chan.payload = out_data_ff;

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking bench for the fixed-size block allocator: drives allocate, free,
// rebuild and unused requests, predicts every response and checks it field by field.
// Depends on fsba_pkg, the channel interfaces in fsba_if.sv and the design top.
`timescale 1ns / 1ps

module tb;

   localparam int POOL_SLOTS    = fsba_pkg::MAX_BLOCKS_DEFAULT;
   localparam int SLOT_BITS     = $clog2(POOL_SLOTS);
   localparam int WORD          = fsba_pkg::WORD_BYTES_DEFAULT;
   localparam int GAP_MAX       = 17;
   localparam int SETTLE_CYCLES = POOL_SLOTS + 44;
   localparam int PHASE_ITEMS   = 145;
   localparam int PHASES        = 8;
   localparam logic [fsba_pkg::OPERATION_WIDTH-1:0] OP_UNUSED = 2'd3;

   logic                                clock;
   logic                                reset;
   logic                                csr_psel;
   logic                                csr_penable;
   logic                                csr_pwrite;
   logic [fsba_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [fsba_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [fsba_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                                csr_pready;

   fsba_req_if req_bus();
   fsba_rsp_if rsp_bus();

   fixed_size_block_allocator uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Shadow of the pool: links, head, free count and the two registers
   int                         pool_link [POOL_SLOTS];
   int                         pool_head;
   int                         pool_free;
   logic [8:0]                 cfg_count;
   logic [15:0]                cfg_bytes;
   int                         held_blocks [$];
   fsba_pkg::rsp_type          expected_rsp_q [$];
   int                         error_count;
   bit                         no_idle;

   // Clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case a handshake never completes
   initial begin
      #10_000_000;
      $display("fixed_size_block_allocator regression: fail");
      $finish;
   end

   // Ascending list 0..n-1 with the count clamped to the pool size
   function automatic void relink_pool();
      int n;
      n = (cfg_count > POOL_SLOTS) ? POOL_SLOTS : int'(cfg_count);
      for (int i = 0; i < POOL_SLOTS; i++)
         pool_link[i[SLOT_BITS-1:0]] = (i + 1 < n) ? i + 1 : POOL_SLOTS;
      pool_head = (n > 0) ? 0 : POOL_SLOTS;
      pool_free = n;
      held_blocks.delete();
   endfunction

   // Apply one request to the shadow pool and return the response it gives
   function automatic fsba_pkg::rsp_type pool_step(logic [1:0] op, logic [7:0] idx);
      fsba_pkg::rsp_type r;
      int                stride;
      r = '0;
      stride = (cfg_bytes == 0) ? WORD : ((int'(cfg_bytes) + WORD - 1) / WORD) * WORD;
      case (op)
         fsba_pkg::OP_ALLOC: begin
            if (pool_head >= POOL_SLOTS) begin
               r.status = fsba_pkg::ST_EMPTY;
            end else begin
               r.status       = fsba_pkg::ST_OK;
               r.block_index  = fsba_pkg::BLOCK_INDEX_WIDTH'(pool_head);
               r.block_offset = fsba_pkg::OFFSET_WIDTH'(WORD + pool_head * stride);
               held_blocks.push_back(pool_head);
               pool_head = pool_link[pool_head[SLOT_BITS-1:0]];
               if (pool_free > 0) pool_free--;
            end
         end
         fsba_pkg::OP_FREE: begin
            if (idx >= cfg_count || int'(idx) >= POOL_SLOTS) begin
               r.status = fsba_pkg::ST_RANGE;
            end else begin
               r.status = fsba_pkg::ST_OK;
               pool_link[idx] = pool_head;
               pool_head = int'(idx);
               if (pool_free < int'(fsba_pkg::COUNT_MAX)) pool_free++;
            end
         end
         fsba_pkg::OP_REBUILD: begin
            relink_pool();
         end
         default: ;
      endcase
      r.free_count = fsba_pkg::COUNT_WIDTH'(pool_free);
      return r;
   endfunction

   task automatic report(string what, int got, int want);
      $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // One request transaction; valid stays high when the next one follows at once
   task automatic send_req(logic [1:0] op, logic [7:0] idx);
      fsba_pkg::req_type p;
      int                gap;
      p.operation  = op;
      p.free_index = idx;
      gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= p;
      // ready is sampled mid-cycle, ahead of the edge that takes the transaction
      @(negedge clock);
      while (!req_bus.ready) @(negedge clock);
      @(posedge clock);
      expected_rsp_q.push_back(pool_step(op, idx));
   endtask

   task automatic stop_req();
      req_bus.valid <= 1'b0;
   endtask

   task automatic wait_drain();
      @(posedge clock);
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   // Register write followed by a readback; only with the allocator idle
   task automatic write_reg(fsba_pkg::reg_index_type which, logic [31:0] value);
      logic [31:0] got;
      logic [31:0] want;
      stop_req();
      wait_drain();
      // let a background relink finish before touching the registers
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_paddr   <= {which, 2'b00};
      csr_pwdata  <= value;
      csr_pwrite  <= 1'b1;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (which == fsba_pkg::REG_BLOCK_COUNT) begin
         cfg_count = value[8:0];
         want = {23'b0, value[8:0]};
      end else begin
         cfg_bytes = value[15:0];
         want = {16'b0, value[15:0]};
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_pwrite <= 1'b0;
      csr_psel   <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got != want) report("register readback", int'(got), int'(want));
   endtask

   // Response side: random stalls, then compare with the oldest prediction
   initial begin
      fsba_pkg::rsp_type want;
      fsba_pkg::rsp_type got;
      int                gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         // valid and payload are sampled mid-cycle, ahead of the taking edge
         @(negedge clock);
         while (!rsp_bus.valid) @(negedge clock);
         got = rsp_bus.payload;
         if (expected_rsp_q.size() == 0) begin
            report("response with none pending, free_count", int'(got.free_count), 0);
         end else begin
            want = expected_rsp_q.pop_front();
            if (got.status != want.status)
               report("status", int'(got.status), int'(want.status));
            if (got.block_index != want.block_index)
               report("block_index", int'(got.block_index), int'(want.block_index));
            if (got.block_offset != want.block_offset)
               report("block_offset", int'(got.block_offset), int'(want.block_offset));
            if (got.free_count != want.free_count)
               report("free_count", int'(got.free_count), int'(want.free_count));
         end
         @(posedge clock);
      end
   end

   // Field extremes, unused opcode, zero and full block sizes, tiny/empty/clamped pools
   task automatic test_directed_edges();
      send_req(fsba_pkg::OP_ALLOC, 8'h00);
      send_req(fsba_pkg::OP_ALLOC, 8'hFF);
      send_req(fsba_pkg::OP_FREE, 8'hFF);
      send_req(fsba_pkg::OP_ALLOC, 8'h00);
      send_req(OP_UNUSED, 8'hAA);
      send_req(fsba_pkg::OP_FREE, 8'h00);
      // widest block: top index gives the largest offset
      write_reg(fsba_pkg::REG_BLOCK_BYTES, 32'd65535);
      send_req(fsba_pkg::OP_FREE, 8'hFF);
      send_req(fsba_pkg::OP_ALLOC, 8'h55);
      write_reg(fsba_pkg::REG_BLOCK_BYTES, 32'd0);
      send_req(fsba_pkg::OP_ALLOC, 8'h00);
      // single-block pool: grant, then empty, then range checks
      write_reg(fsba_pkg::REG_BLOCK_COUNT, 32'd1);
      send_req(fsba_pkg::OP_REBUILD, 8'hFF);
      send_req(fsba_pkg::OP_ALLOC, 8'h00);
      send_req(fsba_pkg::OP_ALLOC, 8'h00);
      send_req(fsba_pkg::OP_FREE, 8'h01);
      send_req(fsba_pkg::OP_FREE, 8'h00);
      send_req(fsba_pkg::OP_FREE, 8'hFF);
      // zero count builds an empty list
      write_reg(fsba_pkg::REG_BLOCK_COUNT, 32'd0);
      send_req(fsba_pkg::OP_REBUILD, 8'h00);
      send_req(fsba_pkg::OP_ALLOC, 8'h00);
      send_req(fsba_pkg::OP_FREE, 8'h00);
      // count above the pool size is clamped at rebuild
      write_reg(fsba_pkg::REG_BLOCK_COUNT, 32'd511);
      send_req(fsba_pkg::OP_REBUILD, 8'h00);
      send_req(fsba_pkg::OP_FREE, 8'hFF);
      send_req(fsba_pkg::OP_ALLOC, 8'h00);
      send_req(OP_UNUSED, 8'h55);
   endtask

   // Free counter saturation at zero and at its maximum through double frees
   task automatic test_count_limits();
      write_reg(fsba_pkg::REG_BLOCK_COUNT, 32'd1);
      write_reg(fsba_pkg::REG_BLOCK_BYTES, 32'd8);
      send_req(fsba_pkg::OP_REBUILD, 8'h00);
      send_req(fsba_pkg::OP_FREE, 8'h00);
      repeat (4) send_req(fsba_pkg::OP_ALLOC, 8'h00);
      write_reg(fsba_pkg::REG_BLOCK_COUNT, 32'd256);
      send_req(fsba_pkg::OP_REBUILD, 8'h00);
      no_idle = 1'b1;
      repeat (258) send_req(fsba_pkg::OP_FREE, 8'h07);
      no_idle = 1'b0;
      repeat (3) send_req(fsba_pkg::OP_ALLOC, 8'h00);
      send_req(fsba_pkg::OP_REBUILD, 8'h00);
   endtask

   // One random request: mostly allocates and frees of held blocks, some noise
   task automatic random_item();
      int         pick;
      int         j;
      logic [7:0] idx;
      pick = $urandom_range(0, 99);
      idx  = 8'($urandom_range(0, 255));
      if (cfg_count > 0 && $urandom_range(0, 1) == 1)
         idx = 8'($urandom_range(0, (cfg_count > POOL_SLOTS) ? POOL_SLOTS - 1
                                                             : int'(cfg_count) - 1));
      if (pick < 45) begin
         send_req(fsba_pkg::OP_ALLOC, idx);
      end else if (pick < 85) begin
         if (held_blocks.size() > 0) begin
            j   = $urandom_range(0, held_blocks.size() - 1);
            idx = 8'(held_blocks[j]);
            held_blocks.delete(j);
         end
         send_req(fsba_pkg::OP_FREE, idx);
      end else if (pick < 93) begin
         send_req(fsba_pkg::OP_FREE, idx);
      end else if (pick < 97) begin
         send_req(fsba_pkg::OP_REBUILD, idx);
      end else begin
         send_req(OP_UNUSED, idx);
      end
   endtask

   // Random traffic over a series of pool settings
   task automatic test_random_traffic();
      int n;
      int b;
      int pause_at;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin n = 256; b = 8;     end
            1: begin n = 1;   b = 0;     end
            2: begin n = 17;  b = 65535; end
            3: begin n = 0;   b = 100;   end
            4: begin n = 300; b = 13;    end
            5: begin n = 2;   b = 7;     end
            default: begin
               n = $urandom_range(1, 256);
               b = $urandom_range(8, 65535);
            end
         endcase
         write_reg(fsba_pkg::REG_BLOCK_COUNT, n);
         write_reg(fsba_pkg::REG_BLOCK_BYTES, b);
         // one phase keeps the old list so the new bound applies to frees alone
         if (phase != 4) send_req(fsba_pkg::OP_REBUILD, 8'($urandom_range(0, 255)));
         pause_at = $urandom_range(20, PHASE_ITEMS - 20);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if (k == pause_at) begin
               stop_req();
               wait_drain();
            end
            random_item();
         end
      end
      no_idle = 1'b0;
   endtask

   // Sequence of tests
   initial begin
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.payload <= '0;
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      csr_paddr       <= '0;
      csr_pwdata      <= '0;
      error_count = 0;
      no_idle     = 1'b0;
      cfg_count   = 9'd256;
      cfg_bytes   = 16'd8;
      relink_pool();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_edges();
      test_count_limits();
      test_random_traffic();
      stop_req();
      wait_drain();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("fixed_size_block_allocator regression: pass");
      else
         $display("fixed_size_block_allocator regression: fail");
      $finish;
   end

endmodule
